// ===== rtl/opfa_pkg.sv =====
`default_nettype none

package opfa_pkg;

   localparam int PAGES = 64;
   localparam int PAGE_BYTES = 2048;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int IDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int CNT_W = $clog2(PAGES + 1);
   localparam int PIU_W = 7;
   localparam logic [PIU_W-1:0] PAGES_IN_USE_RESET = 7'd64;

   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_FREE    = 2'd1,
      REQ_RELEASE = 2'd2,
      REQ_NOP     = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_FREE    = 2'd1,
      ST_MISALIGNED = 2'd2,
      ST_OUTSIDE    = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_HEAP_BASE    = 1'b0,
      CSR_PAGES_IN_USE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_FREE,
      S_RELEASE,
      S_RESP
   } state_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [7:0]   owner_tag;
      logic [31:0]  page_addr_in;
   } req_word_type;

   typedef struct packed {
      logic [31:0] page_addr_out;
      status_type  status;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic alloc_step;
      logic free_exec;
      logic rel_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic alloc_done;
      logic rel_done;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== rtl/opfa_datapath.sv =====
`default_nettype none

module opfa_datapath import opfa_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire csr_index_type csr_index,
   input  wire logic [31:0]   csr_data,
   input  wire req_word_type  req_word,
   input  wire ctrl_cmd_type  cmd,
   output dp_stat_type        stat,
   output rsp_word_type       rsp_word
);

   logic [31:0]      base_ff, base_in;
   logic [PIU_W-1:0] count_ff, count_in;
   logic [PAGES-1:0] used_ff, used_in;
   logic             chk_vld_ff, chk_vld_in;

   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [7:0]       tag_ff, tag_in;
   logic [31:0]      req_addr_ff, req_addr_in;
   logic [31:0]      rsp_addr_ff, rsp_addr_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [7:0]       owner_rd_ff;

   logic [7:0]       owner_mem [PAGES];

   logic [CNT_W-1:0] managed;
   logic             scan_end;
   logic [IDX_W-1:0] cur;
   logic [31:0]      offs;
   logic [31:0]      offs_page;
   logic             misaligned;
   logic             outside;
   logic [31:0]      alloc_addr;
   logic             owner_we;

   assign csr_ready = 1'b1;

   assign managed = (32'(count_ff) > 32'(PAGES)) ? CNT_W'(PAGES) : CNT_W'(count_ff);
   assign scan_end = (idx_ff >= managed);
   assign cur = idx_ff[IDX_W-1:0];
   assign offs = req_addr_ff - base_ff;
   assign offs_page = offs >> PAGE_SHIFT;
   assign misaligned = (offs[PAGE_SHIFT-1:0] != '0);
   assign outside = (offs_page >= 32'(managed));
   assign alloc_addr = base_ff + (32'(idx_ff) << PAGE_SHIFT);
   assign owner_we = cmd.alloc_step && !scan_end && !used_ff[cur];

   assign stat.alloc_done = scan_end || !used_ff[cur];
   assign stat.rel_done = scan_end && !chk_vld_ff;

   assign rsp_word.page_addr_out = rsp_addr_ff;
   assign rsp_word.status = rsp_status_ff;

   always_comb begin
      base_in = base_ff;
      count_in = count_ff;
      used_in = used_ff;
      chk_vld_in = chk_vld_ff;
      idx_in = idx_ff;
      chk_idx_in = chk_idx_ff;
      tag_in = tag_ff;
      req_addr_in = req_addr_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_HEAP_BASE: base_in = csr_data;
            CSR_PAGES_IN_USE: count_in = csr_data[PIU_W-1:0];
            default: base_in = base_ff;
         endcase
      end

      if (cmd.load) begin
         idx_in = '0;
         chk_vld_in = 1'b0;
         tag_in = req_word.owner_tag;
         req_addr_in = req_word.page_addr_in;
         rsp_addr_in = '0;
         rsp_status_in = ST_OK;
      end

      if (cmd.alloc_step) begin
         priority if (scan_end) begin
            rsp_status_in = ST_NO_FREE;
         end else if (!used_ff[cur]) begin
            used_in[cur] = 1'b1;
            rsp_addr_in = alloc_addr;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end

      if (cmd.free_exec) begin
         priority if (misaligned) begin
            rsp_status_in = ST_MISALIGNED;
         end else if (outside) begin
            rsp_status_in = ST_OUTSIDE;
         end else begin
            used_in[offs_page[IDX_W-1:0]] = 1'b0;
         end
      end

      if (cmd.rel_step) begin
         // The owner read issued for one page is registered and checked in the next cycle.
         if (!scan_end) begin
            chk_vld_in = 1'b1;
            chk_idx_in = cur;
            idx_in = idx_ff + 1'b1;
         end else begin
            chk_vld_in = 1'b0;
         end
         if (chk_vld_ff && used_ff[chk_idx_ff] && (owner_rd_ff == tag_ff)) begin
            used_in[chk_idx_ff] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         count_ff <= PAGES_IN_USE_RESET;
         used_ff <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         base_ff <= base_in;
         count_ff <= count_in;
         used_ff <= used_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      chk_idx_ff <= chk_idx_in;
      tag_ff <= tag_in;
      req_addr_ff <= req_addr_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Owner tags are only ever checked for pages marked in use, so the store needs no clearing.
   always_ff @(posedge clock) begin
      if (owner_we) begin
         owner_mem[cur] <= tag_ff;
      end
      owner_rd_ff <= owner_mem[cur];
   end

endmodule

`default_nettype wire

// ===== rtl/opfa_controller.sv =====
`default_nettype none

module opfa_controller import opfa_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_kind_type req_kind,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output ctrl_cmd_type      cmd,
   input  wire dp_stat_type  stat
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  REQ_ALLOC: state_in = S_ALLOC;
                  REQ_FREE: state_in = S_FREE;
                  REQ_RELEASE: state_in = S_RELEASE;
                  REQ_NOP: state_in = S_RESP;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_ALLOC: begin
            if (stat.alloc_done) begin
               state_in = S_RESP;
            end
         end
         S_FREE: state_in = S_RESP;
         S_RELEASE: begin
            if (stat.rel_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_RESP);
      cmd.load = (state_ff == S_IDLE) && req_valid;
      cmd.alloc_step = (state_ff == S_ALLOC);
      cmd.free_exec = (state_ff == S_FREE);
      cmd.rel_step = (state_ff == S_RELEASE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/owned_page_frame_allocator.sv =====
`default_nettype none

// Port group   Handshake            Word
// req_         req_valid/req_stall  req_word   (request type, owner tag, page address)
// rsp_         rsp_valid/rsp_stall  rsp_word   (allocated address, status)
// csr_         csr_valid/csr_ready  csr_index, csr_data
//
// One request is handled at a time; the page table is walked one page per cycle.
// Allocate offers its word once the walk reaches the first free page (or passes the last
// managed page when none is free); free checks its address once, the ignored type goes
// straight to its result. Release-owner walks every managed page: owner reads are registered.
// Synchronous reset frees every page at once; no clearing pass is needed.
// While a result word is stalled, req_stall stays high.

module owned_page_frame_allocator import opfa_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_word_type  req_word,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_word_type       rsp_word,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire csr_index_type csr_index,
   input  wire logic [31:0]   csr_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   opfa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_word.req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   opfa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

// ===== bench/owned_page_frame_allocator_checker.sv =====
`default_nettype none

module owned_page_frame_allocator_checker import opfa_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_stall,
   input  wire req_word_type  req_word,
   input  wire logic          rsp_valid,
   input  wire logic          rsp_stall,
   input  wire rsp_word_type  rsp_word,
   input  wire logic          csr_valid,
   input  wire logic          csr_ready,
   input  wire csr_index_type csr_index,
   input  wire logic [31:0]   csr_data,
   output int                 pending,
   output int                 error_count
);

   // Private copy of the page table and the two settings.
   bit               page_taken [PAGES];
   logic [7:0]       page_holder [PAGES];
   logic [31:0]      heap_origin;
   logic [PIU_W-1:0] page_limit;

   rsp_word_type     awaited_words [$];
   rsp_word_type     awaited;

   initial begin
      pending = 0;
      error_count = 0;
   end

   task automatic note_mismatch(input string msg);
      error_count++;
      if (error_count <= 50) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   function automatic rsp_word_type serve_page_request(input req_word_type w);
      rsp_word_type outcome;
      logic [31:0]  offset;
      logic [31:0]  slot;
      int unsigned  managed;
      int unsigned  i;
      bit           placed;

      outcome.page_addr_out = '0;
      outcome.status = ST_OK;
      managed = (page_limit > PAGES) ? PAGES : page_limit;
      placed = 1'b0;
      case (w.req_type)
         REQ_ALLOC: begin
            outcome.status = ST_NO_FREE;
            for (i = 0; i < managed; i++) begin
               if (!placed && !page_taken[i]) begin
                  page_taken[i] = 1'b1;
                  page_holder[i] = w.owner_tag;
                  outcome.page_addr_out = heap_origin + 32'(i * PAGE_BYTES);
                  outcome.status = ST_OK;
                  placed = 1'b1;
               end
            end
         end
         REQ_FREE: begin
            // The offset wraps modulo 2^32, so addresses below the heap can still land on it.
            offset = w.page_addr_in - heap_origin;
            if (offset % PAGE_BYTES != 0) begin
               outcome.status = ST_MISALIGNED;
            end else begin
               slot = offset / PAGE_BYTES;
               if (slot >= managed) begin
                  outcome.status = ST_OUTSIDE;
               end else begin
                  page_taken[slot] = 1'b0;
               end
            end
         end
         REQ_RELEASE: begin
            for (i = 0; i < managed; i++) begin
               if (page_taken[i] && page_holder[i] == w.owner_tag) begin
                  page_taken[i] = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      return outcome;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (page_taken[i]) begin
            page_taken[i] = 1'b0;
            page_holder[i] = '0;
         end
         heap_origin = '0;
         page_limit = PAGES_IN_USE_RESET;
         awaited_words.delete();
      end else begin
         // A request cannot be taken while a response is offered (req_stall is high then); responses are checked first.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_words.size() == 0) begin
               note_mismatch($sformatf("unexpected response word addr %h status %s",
                                       rsp_word.page_addr_out, rsp_word.status.name()));
            end else begin
               awaited = awaited_words.pop_front();
               if (rsp_word.page_addr_out !== awaited.page_addr_out) begin
                  note_mismatch($sformatf("page_addr_out %h, expected %h",
                                          rsp_word.page_addr_out, awaited.page_addr_out));
               end
               if (rsp_word.status !== awaited.status) begin
                  note_mismatch($sformatf("status %0d, expected %s",
                                          rsp_word.status, awaited.status.name()));
               end
            end
         end
         if (req_valid && !req_stall) begin
            awaited_words.push_back(serve_page_request(req_word));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEAP_BASE:    heap_origin = csr_data;
               CSR_PAGES_IN_USE: page_limit = csr_data[PIU_W-1:0];
               default: begin
               end
            endcase
         end
      end
      pending = awaited_words.size();
   end

endmodule

`default_nettype wire

// ===== bench/owned_page_frame_allocator_tb.sv =====
`default_nettype none

module owned_page_frame_allocator_tb;
   import opfa_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic          clock;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_word_type  req_word = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_word_type  rsp_word;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_HEAP_BASE;
   logic [31:0]   csr_data = '0;

   int            pending;
   int            error_count;
   int            cycle_count = 0;
   int            stall_left = 0;
   bit            idling = 1'b0;

   logic [7:0]    owner_pool [4] = '{8'h00, 8'h01, 8'h80, 8'hFF};

   owned_page_frame_allocator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   owned_page_frame_allocator_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .pending(pending), .error_count(error_count)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("owned_page_frame_allocator_tb: errors");
         $finish;
      end
   end

   // Result side back-pressure in bursts, started only while idling is set.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic req_word_type page_request(input req_kind_type kind,
                                                 input logic [7:0] tag,
                                                 input logic [31:0] addr);
      req_word_type w;
      w.req_type = kind;
      w.owner_tag = tag;
      w.page_addr_in = addr;
      return w;
   endfunction

   // Entered and left at a falling edge; valid stays high until the next word or an idle gap.
   task automatic offer_request(input req_word_type w);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_outstanding();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic program_heap(input logic [31:0] base, input logic [PIU_W-1:0] count);
      int k;
      for (k = 0; k < 2; k++) begin
         csr_index <= (k == 0) ? CSR_HEAP_BASE : CSR_PAGES_IN_USE;
         csr_data <= (k == 0) ? base : 32'(count);
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [31:0]      base;
      logic [PIU_W-1:0] count;
      logic [7:0]       tag;
      int               managed;
      int               alloc_share;
      int               pick;
      int               phase;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: heap at address 0, all 64 pages managed.
      offer_request(page_request(REQ_ALLOC, 8'h00, '0));
      offer_request(page_request(REQ_ALLOC, 8'hFF, '0));
      offer_request(page_request(REQ_FREE, 8'h00, 32'h0000_0000));
      offer_request(page_request(REQ_FREE, 8'h00, 32'h0000_0000));
      offer_request(page_request(REQ_FREE, 8'h00, 32'h0000_0001));
      offer_request(page_request(REQ_FREE, 8'h00, 32'(PAGES * PAGE_BYTES)));
      offer_request(page_request(REQ_FREE, 8'hFF, 32'hFFFF_F800));
      offer_request(page_request(REQ_FREE, 8'hFF, 32'hFFFF_FFFF));
      offer_request(page_request(REQ_NOP, 8'hFF, 32'hFFFF_FFFF));
      offer_request(page_request(REQ_RELEASE, 8'hFF, '0));
      offer_request(page_request(REQ_RELEASE, 8'h5A, '0));

      // A single page at the very top of the address space.
      drain_outstanding();
      program_heap(32'hFFFF_F800, 7'd1);
      offer_request(page_request(REQ_ALLOC, 8'h12, '0));
      offer_request(page_request(REQ_ALLOC, 8'h34, '0));
      offer_request(page_request(REQ_FREE, 8'h00, 32'h0000_0000));
      offer_request(page_request(REQ_FREE, 8'h00, 32'hFFFF_F800));

      // Nothing managed at all.
      drain_outstanding();
      program_heap(32'hFFFF_F800, 7'd0);
      offer_request(page_request(REQ_ALLOC, 8'h12, '0));
      offer_request(page_request(REQ_FREE, 8'h00, 32'hFFFF_F800));
      offer_request(page_request(REQ_RELEASE, 8'h12, '0));

      // A count above the table size is held at the table size.
      drain_outstanding();
      program_heap(32'h0000_0000, 7'h7F);
      offer_request(page_request(REQ_ALLOC, 8'hA5, '0));
      offer_request(page_request(REQ_ALLOC, 8'h5A, '0));
      offer_request(page_request(REQ_FREE, 8'h00, 32'(63 * PAGE_BYTES)));

      for (phase = 0; phase < 12; phase++) begin
         drain_outstanding();
         case ($urandom_range(0, 3))
            0: base = '0;
            1: base = 32'hFFFF_FFFF;
            2: base = $urandom & ~32'(PAGE_BYTES - 1);
            default: base = $urandom;
         endcase
         case ($urandom_range(0, 6))
            0: count = 7'd0;
            1: count = 7'd1;
            2: count = 7'd64;
            3: count = 7'h7F;
            4: count = 7'($urandom_range(65, 127));
            5: count = 7'($urandom_range(1, 8));
            default: count = 7'($urandom_range(1, 64));
         endcase
         program_heap(base, count);
         managed = (count > PAGES) ? PAGES : count;
         // The last phases run at full rate on both sides.
         idling = (phase < 10) && ($urandom_range(0, 3) != 0);
         alloc_share = $urandom_range(25, 70);

         repeat (145) begin
            pick = $urandom_range(0, 99);
            tag = ($urandom_range(0, 3) == 0) ? 8'($urandom) : owner_pool[$urandom_range(0, 3)];
            if (pick < alloc_share) begin
               offer_request(page_request(REQ_ALLOC, tag, $urandom));
            end else if (pick < 88) begin
               offer_request(page_request(REQ_FREE, tag,
                  base + 32'($urandom_range(0, managed + 1) * PAGE_BYTES)));
            end else if (pick < 94) begin
               offer_request(page_request(REQ_RELEASE, tag, $urandom));
            end else if (pick < 97) begin
               offer_request(page_request(REQ_FREE, tag, $urandom));
            end else begin
               offer_request(page_request(REQ_NOP, tag, $urandom));
            end
         end
      end

      drain_outstanding();
      repeat (80) @(negedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("owned_page_frame_allocator_tb: clean");
      end else begin
         $display("owned_page_frame_allocator_tb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/opfa_pkg.sv
rtl/opfa_datapath.sv
rtl/opfa_controller.sv
rtl/owned_page_frame_allocator.sv
bench/owned_page_frame_allocator_checker.sv
bench/owned_page_frame_allocator_tb.sv
